@@ hdl/bitmap_text_to_rectangles_core_defines.svh @@
// Assertion macros used by the checker file.
`ifndef BITMAP_TEXT_TO_RECTANGLES_CORE_DEFINES_SVH
`define BITMAP_TEXT_TO_RECTANGLES_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define BTTR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define BTTR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bttr_pkg.sv @@
package bttr_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CODE   = 2'd2;

  localparam logic [7:0] CHAR_NONE    = 8'd0;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  localparam logic [3:0] GLYPH_SIDE_RESET = 4'd8;
  localparam logic [7:0] FIRST_CODE_RESET = 8'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADDR,
    ST_FETCH,
    ST_WALK,
    ST_FINISH
  } state_t;

endpackage

@@ hdl/bitmap_text_to_rectangles_core.sv @@
// Bitmap text renderer. Load items (opcode 0) write one byte of the font memory; the memory
// is not cleared at reset, so glyphs must be loaded before use. A text item (opcode 1) holds
// in_ready low while it is handled: code 0, newline and space end in the dispatch state; a
// drawn character passes dispatch, 8 steps of the glyph address unit, a read for each font byte
// touched, a step for each glyph bit and a closing state, and out_ready can stall a square.
// The pace is set by the single bit walk, reading one glyph bit a cycle, apart from font reads
// and out_ready stalls, from the font memory, which has one read port, and by the address unit,
// which forms the glyph bit offset one bit of the glyph number per cycle. One square a cycle can
// leave while out_ready is high; the final square of a character carries last_square. The
// configuration port is always ready; the user must write it only while the block is idle, as
// the block itself does not enforce this.
module bitmap_text_to_rectangles_core #(
  parameter int FONT_BYTES     = 2048,
  parameter int MAX_GLYPH_SIDE = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bttr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           opcode,
  input  logic [10:0]                    font_address,
  input  logic [7:0]                     font_byte,
  input  logic [7:0]                     char_code,
  input  logic                           begins_string,
  input  logic [7:0]                     start_x,
  input  logic [7:0]                     start_y,
  input  logic [15:0]                    text_color,
  input  logic [3:0]                     scale,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     rect_x,
  output logic [7:0]                     rect_y,
  output logic [3:0]                     rect_side,
  output logic [15:0]                    pixel_color,
  output logic                           last_square
);

  import bttr_pkg::*;

  localparam int SIDE_W  = $clog2(MAX_GLYPH_SIDE + 1);
  localparam int AREA_W  = 2 * SIDE_W;
  localparam int PROD_W  = SIDE_W + 4;
  localparam int AW      = $clog2(FONT_BYTES);
  localparam int ACC_W   = AW + 3;
  localparam int BIT_MOD = 8 * FONT_BYTES;
  localparam int LDW     = ((AW > 11) ? AW : 11) + 1;

  localparam logic [ACC_W+1:0] MOD1     = (ACC_W + 2)'(BIT_MOD);
  localparam logic [ACC_W+1:0] MOD2     = (ACC_W + 2)'(2 * BIT_MOD);
  localparam logic [AW-1:0]    LAST_ADR = AW'(FONT_BYTES - 1);
  localparam logic [LDW-1:0]   LD_LIMIT = LDW'(FONT_BYTES);

  state_t state, state_next;

  logic [3:0]        glyph_width;
  logic [3:0]        glyph_height;
  logic [7:0]        first_code;

  logic [7:0]        cursor_x;
  logic [7:0]        cursor_y;
  logic [7:0]        line_start_x;

  logic [7:0]        char_q;
  logic [15:0]       color_q;
  logic [3:0]        scale_q;
  logic [SIDE_W-1:0] w_eff;
  logic [SIDE_W-1:0] h_eff;
  logic [7:0]        x_adv;
  logic [AREA_W-1:0] area;
  logic [7:0]        glyph_num;
  logic [ACC_W-1:0]  acc;
  logic [2:0]        step;
  logic [AW-1:0]     byte_addr;
  logic [2:0]        bit_pos;
  logic [SIDE_W-1:0] col;
  logic [SIDE_W-1:0] row;
  logic [7:0]        col_off;
  logic [7:0]        row_off;
  logic              pend_valid;
  logic [7:0]        pend_x;
  logic [7:0]        pend_y;

  logic [7:0]        font_mem [FONT_BYTES];
  logic [7:0]        mem_q;

  // combinational helpers
  logic [SIDE_W-1:0] w_clamp, h_clamp;
  logic [3:0]        scale_eff;
  logic [PROD_W-1:0] wprod, hprod;
  logic [7:0]        spacing;
  logic [AREA_W-1:0] area_c;
  logic [ACC_W+1:0]  acc_sum, acc_red;
  logic [LDW-1:0]    ld_addr;
  logic              font_we;
  logic              accept, bit_set, out_free, stall, last_bit;
  logic              push_mid, push_end, walk_adv, fin_done;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [3:0] v);
    logic [SIDE_W-1:0] r;
    if (v == 4'd0) begin
      r = SIDE_W'(1);
    end else if (int'(v) > MAX_GLYPH_SIDE) begin
      r = SIDE_W'(MAX_GLYPH_SIDE);
    end else begin
      r = SIDE_W'(v);
    end
    return r;
  endfunction

  assign w_clamp   = clamp_side(glyph_width);
  assign h_clamp   = clamp_side(glyph_height);
  assign scale_eff = (scale == 4'd0) ? 4'd1 : scale;
  assign wprod     = PROD_W'(w_eff) * PROD_W'(scale_q);
  assign hprod     = PROD_W'(h_eff) * PROD_W'(scale_q);
  assign spacing   = 8'(wprod >> 1);
  assign area_c    = AREA_W'(w_eff) * AREA_W'(h_eff);

  // one step of the glyph offset: double and add, reduced modulo the font size in bits
  assign acc_sum = {1'b0, acc, 1'b0} + (glyph_num[7] ? (ACC_W + 2)'(area) : '0);
  always_comb begin
    if (acc_sum >= MOD2) begin
      acc_red = acc_sum - MOD2;
    end else if (acc_sum >= MOD1) begin
      acc_red = acc_sum - MOD1;
    end else begin
      acc_red = acc_sum;
    end
  end

  assign ld_addr   = LDW'(font_address);
  assign accept    = in_valid && in_ready;
  assign font_we   = accept && (opcode == OP_LOAD) && (ld_addr < LD_LIMIT);
  assign bit_set   = mem_q[bit_pos];
  assign out_free  = !out_valid || out_ready;
  assign last_bit  = (col == w_eff - SIDE_W'(1)) && (row == h_eff - SIDE_W'(1));

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cfg_ready  = 1'b1;
    stall      = 1'b0;
    push_mid   = 1'b0;
    push_end   = 1'b0;
    walk_adv   = 1'b0;
    fin_done   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && opcode == OP_TEXT) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (char_q == CHAR_NONE || char_q == CHAR_NEWLINE || char_q == CHAR_SPACE) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        if (step == 3'd7) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_WALK;
      end
      ST_WALK: begin
        stall    = bit_set && pend_valid && !out_free;
        push_mid = bit_set && pend_valid && out_free;
        walk_adv = !stall;
        if (!stall) begin
          if (last_bit) begin
            state_next = ST_FINISH;
          end else if (bit_pos == 3'd7) begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_FINISH: begin
        push_end = pend_valid && out_free;
        fin_done = !pend_valid || out_free;
        if (fin_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width  <= GLYPH_SIDE_RESET;
      glyph_height <= GLYPH_SIDE_RESET;
      first_code   <= FIRST_CODE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GLYPH_WIDTH:  glyph_width  <= cfg_data[3:0];
        CFG_GLYPH_HEIGHT: glyph_height <= cfg_data[3:0];
        CFG_FIRST_CODE:   first_code   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[ld_addr[AW-1:0]] <= font_byte;
    end
    mem_q <= font_mem[byte_addr];
  end

  // cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= '0;
      cursor_y     <= '0;
      line_start_x <= '0;
    end else begin
      if (accept && opcode == OP_TEXT && begins_string) begin
        cursor_x     <= start_x;
        line_start_x <= start_x;
        cursor_y     <= start_y;
      end
      if (state == ST_DISPATCH) begin
        if (char_q == CHAR_NEWLINE) begin
          cursor_x <= line_start_x;
          cursor_y <= cursor_y + 8'(hprod) + spacing;
        end else if (char_q == CHAR_SPACE) begin
          cursor_x <= cursor_x + 8'(wprod) + spacing;
        end
      end
      if (fin_done) begin
        cursor_x <= cursor_x + x_adv;
      end
    end
  end

  // item working registers
  always_ff @(posedge clk) begin
    if (accept && opcode == OP_TEXT) begin
      char_q    <= char_code;
      color_q   <= text_color;
      scale_q   <= scale_eff;
      w_eff     <= w_clamp;
      h_eff     <= h_clamp;
      glyph_num <= char_code - first_code;
    end
    case (state)
      ST_DISPATCH: begin
        x_adv <= 8'(wprod) + spacing;
        area  <= area_c;
        acc   <= '0;
        step  <= '0;
      end
      ST_ADDR: begin
        acc       <= ACC_W'(acc_red);
        glyph_num <= {glyph_num[6:0], 1'b0};
        step      <= step + 3'd1;
        if (step == 3'd7) begin
          byte_addr <= acc_red[ACC_W-1:3];
          bit_pos   <= acc_red[2:0];
          col       <= '0;
          row       <= '0;
          col_off   <= '0;
          row_off   <= '0;
        end
      end
      ST_WALK: begin
        if (walk_adv) begin
          if (col == w_eff - SIDE_W'(1)) begin
            col     <= '0;
            col_off <= '0;
            row     <= row + SIDE_W'(1);
            row_off <= row_off + 8'(scale_q);
          end else begin
            col     <= col + SIDE_W'(1);
            col_off <= col_off + 8'(scale_q);
          end
          bit_pos <= bit_pos + 3'd1;
          if (bit_pos == 3'd7) begin
            byte_addr <= (byte_addr == LAST_ADR) ? '0 : byte_addr + AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // hold one square back so the final one can be flagged
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (state == ST_DISPATCH) begin
      pend_valid <= 1'b0;
    end else if (walk_adv && bit_set) begin
      pend_valid <= 1'b1;
    end else if (push_end) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_adv && bit_set) begin
      pend_x <= cursor_x + col_off;
      pend_y <= cursor_y + row_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_mid || push_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_end) begin
      rect_x      <= pend_x;
      rect_y      <= pend_y;
      rect_side   <= scale_q;
      pixel_color <= color_q;
      last_square <= push_end;
    end
  end

endmodule

@@ hdl/bttr_checker.sv @@
`include "bitmap_text_to_rectangles_core_defines.svh"

module bttr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  rect_x,
  input logic [7:0]  rect_y,
  input logic [3:0]  rect_side,
  input logic [15:0] pixel_color,
  input logic        last_square
);

  import bttr_pkg::*;

  `BTTR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rect_x) && $stable(rect_y) && $stable(rect_side) && $stable(pixel_color) && $stable(last_square), "square changed while stalled")

  `BTTR_ASSERT_NXT(a_text_busy, in_valid && in_ready && opcode == OP_TEXT, !in_ready, "text transfer did not make the block busy")

  `BTTR_ASSERT_IMP(a_side_nonzero, out_valid, rect_side != 4'd0, "square with zero side")

  `BTTR_ASSERT_IMP(a_char_open, out_valid && !last_square, !in_ready, "ready while a character is still being drawn")

endmodule

bind bitmap_text_to_rectangles_core bttr_checker u_bttr_checker (.*);
